>>> hw/rtl/dbd_pkg.sv
// Package for the dictionary block deframer: field tags, definition classes,
// block type codes and framing constants shared by the interfaces and the core.
// No dependencies.
`timescale 1ns / 1ps

package dbd_pkg;

    localparam int ByteW = 8;
    localparam int KindW = 4;
    localparam int TagW = 3;
    localparam int ClassW = 3;
    localparam int SpeechW = 4;
    localparam int LenW = 32;
    localparam int SubW = 16;
    localparam int LenCntW = 3;

    localparam logic [TagW-1:0] TAG_HEADER = 3'd0;
    localparam logic [TagW-1:0] TAG_LENGTH = 3'd1;
    localparam logic [TagW-1:0] TAG_PAYLOAD = 3'd2;
    localparam logic [TagW-1:0] TAG_PREFIX = 3'd3;
    localparam logic [TagW-1:0] TAG_HEADWORD = 3'd4;
    localparam logic [TagW-1:0] TAG_DEFINITION = 3'd5;
    localparam logic [TagW-1:0] TAG_ALTERNATE = 3'd6;
    localparam logic [TagW-1:0] TAG_AFTER_END = 3'd7;

    localparam logic [ClassW-1:0] CLS_KEEP = 3'd0;
    localparam logic [ClassW-1:0] CLS_NEWLINE = 3'd1;
    localparam logic [ClassW-1:0] CLS_DROPPED = 3'd2;
    localparam logic [ClassW-1:0] CLS_MARKER = 3'd3;
    localparam logic [ClassW-1:0] CLS_SKIPPED = 3'd4;

    localparam logic [KindW-1:0] KIND_ENTRY = 4'd1;
    localparam logic [KindW-1:0] KIND_ENTRY_ALT = 4'd10;
    localparam logic [KindW-1:0] KIND_END = 4'd4;

    localparam logic [3:0] CODE_INLINE_BASE = 4'd4;

    localparam logic [ByteW-1:0] CHAR_NEWLINE = 8'h0a;
    localparam logic [ByteW-1:0] CHAR_MARK = 8'h14;
    localparam logic [ByteW-1:0] CHAR_POS = 8'h02;
    localparam logic [ByteW-1:0] CHAR_DIGIT0 = 8'h30;
    localparam logic [ByteW-1:0] CHAR_DIGIT_MAX = 8'h3a;

    function automatic logic is_entry_kind(input logic [KindW-1:0] kind);
        return (kind == KIND_ENTRY) || (kind == KIND_ENTRY_ALT);
    endfunction

endpackage

>>> hw/rtl/dbd_in_if.sv
// Input channel of the deframer: one stream byte per beat with valid/ready.
// Depends on dbd_pkg.
`timescale 1ns / 1ps

interface dbd_in_if;
    import dbd_pkg::*;

    logic             valid;
    logic             ready;
    logic [ByteW-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

>>> hw/rtl/dbd_out_if.sv
// Result channel of the deframer: one tagged byte per beat with valid/ready.
// Depends on dbd_pkg.
`timescale 1ns / 1ps

interface dbd_out_if;
    import dbd_pkg::*;

    logic               valid;
    logic               ready;
    logic [ByteW-1:0]   out_byte;
    logic [KindW-1:0]   block_kind;
    logic [TagW-1:0]    field_tag;
    logic [ClassW-1:0]  def_class;
    logic [SpeechW-1:0] speech_index;
    logic               speech_valid;
    logic               block_last;
    logic               end_seen;
    logic               format_error;

    modport source (
        output valid, output out_byte, output block_kind, output field_tag,
        output def_class, output speech_index, output speech_valid,
        output block_last, output end_seen, output format_error,
        input ready
    );
    modport sink (
        input valid, input out_byte, input block_kind, input field_tag,
        input def_class, input speech_index, input speech_valid,
        input block_last, input end_seen, input format_error,
        output ready
    );
endinterface

>>> hw/rtl/dictionary_block_deframer_core.sv
// Top level of the dictionary block deframer: framing and entry parser core.
// Depends on dbd_pkg, dbd_in_if and dbd_out_if.
`timescale 1ns / 1ps

// The core tags one byte per clock cycle while bytes arrive and the sink
// takes its results. Each accepted byte is parsed combinationally against
// the block framing, entry field and marker state, and its tagged beat is
// loaded into the result register; the longest path is the 32-bit payload
// down-count and its zero compare. A new byte is taken whenever the result
// register is empty or its beat is taken in the same cycle, so a stalled
// sink holds the input back only as long as it holds the result.
module dictionary_block_deframer_core (
    input logic clk,
    input logic rst_n,
    dbd_in_if.sink in_chan,
    dbd_out_if.source out_chan
);
    import dbd_pkg::*;

    typedef enum logic [1:0] {
        FR_HEADER,
        FR_LENGTH,
        FR_PAYLOAD
    } frame_phase_t;

    typedef enum logic [2:0] {
        EP_HW_LEN,
        EP_HW,
        EP_DEF_HI,
        EP_DEF_LO,
        EP_DEF,
        EP_ALT_LEN,
        EP_ALT
    } entry_phase_t;

    typedef enum logic [1:0] {
        MK_NONE,
        MK_ARMED,
        MK_INDEX,
        MK_SKIP
    } marker_phase_t;

    frame_phase_t       frame_phase_reg, frame_phase_next;
    logic [LenCntW-1:0] len_left_reg, len_left_next;
    logic [LenW-1:0]    len_acc_reg, len_acc_next;
    logic [KindW-1:0]   cur_type_reg, cur_type_next;
    logic [LenW-1:0]    pay_left_reg, pay_left_next;
    entry_phase_t       entry_phase_reg, entry_phase_next;
    logic [SubW-1:0]    sub_left_reg, sub_left_next;
    marker_phase_t      marker_phase_reg, marker_phase_next;
    logic               ended_reg, ended_next;

    logic               out_valid_reg;
    logic [ByteW-1:0]   res_byte_reg;
    logic [KindW-1:0]   res_kind_reg;
    logic [TagW-1:0]    res_tag_reg, res_tag_next;
    logic [ClassW-1:0]  res_class_reg, res_class_next;
    logic [SpeechW-1:0] res_index_reg, res_index_next;
    logic               res_svalid_reg, res_svalid_next;
    logic               res_last_reg, res_last_next;
    logic               res_ended_reg;
    logic               res_err_reg, res_err_next;

    logic               accept;
    logic [ByteW-1:0]   b;
    logic [ByteW-1:0]   b_rel;
    logic [LenCntW-1:0] len_dec;
    logic [LenW-1:0]    pay_dec;
    logic [SubW-1:0]    sub_dec;

    assign in_chan.ready = !out_valid_reg || out_chan.ready;
    assign accept = in_chan.valid && in_chan.ready;
    assign b = in_chan.in_byte;
    assign b_rel = b - CHAR_DIGIT0;
    assign len_dec = (len_left_reg != '0) ? len_left_reg - 1'b1 : '0;
    assign pay_dec = (pay_left_reg != '0) ? pay_left_reg - 1'b1 : '0;

    always_comb
    begin
        frame_phase_next = frame_phase_reg;
        len_left_next = len_left_reg;
        len_acc_next = len_acc_reg;
        cur_type_next = cur_type_reg;
        pay_left_next = pay_left_reg;
        entry_phase_next = entry_phase_reg;
        sub_left_next = sub_left_reg;
        marker_phase_next = marker_phase_reg;
        ended_next = ended_reg;
        res_tag_next = TAG_HEADER;
        res_class_next = CLS_KEEP;
        res_index_next = '0;
        res_svalid_next = 1'b0;
        res_last_next = 1'b0;
        res_err_next = 1'b0;
        sub_dec = (sub_left_reg != '0) ? sub_left_reg - 1'b1 : '0;

        if (ended_reg)
        begin
            res_tag_next = TAG_AFTER_END;
        end
        else
        begin
            unique case (frame_phase_reg)
                FR_LENGTH:
                begin
                    res_tag_next = TAG_LENGTH;
                    len_acc_next = {len_acc_reg[LenW-ByteW-1:0], b};
                    len_left_next = len_dec;
                    if (len_dec == '0)
                    begin
                        if (len_acc_next == '0)
                        begin
                            res_last_next = 1'b1;
                            res_err_next = is_entry_kind(cur_type_reg)
                                && (entry_phase_reg != EP_ALT_LEN);
                            entry_phase_next = EP_HW_LEN;
                            sub_left_next = '0;
                            marker_phase_next = MK_NONE;
                            frame_phase_next = FR_HEADER;
                        end
                        else
                        begin
                            pay_left_next = len_acc_next;
                            frame_phase_next = FR_PAYLOAD;
                        end
                    end
                end
                FR_PAYLOAD:
                begin
                    res_tag_next = TAG_PAYLOAD;
                    if (is_entry_kind(cur_type_reg))
                    begin
                        res_tag_next = TAG_PREFIX;
                        unique case (entry_phase_reg)
                            EP_HW_LEN:
                            begin
                                sub_left_next = {{(SubW-ByteW){1'b0}}, b};
                                entry_phase_next = (b != '0) ? EP_HW : EP_DEF_HI;
                            end
                            EP_HW:
                            begin
                                res_tag_next = TAG_HEADWORD;
                                sub_left_next = sub_dec;
                                if (sub_dec == '0)
                                begin
                                    entry_phase_next = EP_DEF_HI;
                                end
                            end
                            EP_DEF_HI:
                            begin
                                sub_left_next = {b, {(SubW-ByteW){1'b0}}};
                                entry_phase_next = EP_DEF_LO;
                            end
                            EP_DEF_LO:
                            begin
                                sub_left_next = {sub_left_reg[SubW-1:ByteW], b};
                                entry_phase_next = (sub_left_next != '0) ? EP_DEF
                                                                         : EP_ALT_LEN;
                            end
                            EP_DEF:
                            begin
                                res_tag_next = TAG_DEFINITION;
                                if (marker_phase_reg == MK_SKIP)
                                begin
                                    res_class_next = CLS_SKIPPED;
                                end
                                else if (marker_phase_reg == MK_INDEX)
                                begin
                                    res_class_next = CLS_MARKER;
                                    if ((b >= CHAR_DIGIT0) && (b <= CHAR_DIGIT_MAX))
                                    begin
                                        res_index_next = b_rel[SpeechW-1:0];
                                        res_svalid_next = 1'b1;
                                    end
                                    marker_phase_next = MK_SKIP;
                                end
                                else if ((marker_phase_reg == MK_ARMED) && (b == CHAR_POS))
                                begin
                                    res_class_next = CLS_MARKER;
                                    marker_phase_next = MK_INDEX;
                                end
                                else
                                begin
                                    marker_phase_next = MK_NONE;
                                    if (b == CHAR_NEWLINE)
                                    begin
                                        res_class_next = CLS_NEWLINE;
                                    end
                                    else if (b == CHAR_MARK)
                                    begin
                                        res_class_next = CLS_DROPPED;
                                        if (sub_left_reg >= SubW'(3))
                                        begin
                                            marker_phase_next = MK_ARMED;
                                        end
                                    end
                                end
                                sub_left_next = sub_dec;
                                if (sub_dec == '0)
                                begin
                                    entry_phase_next = EP_ALT_LEN;
                                    marker_phase_next = MK_NONE;
                                end
                            end
                            EP_ALT:
                            begin
                                res_tag_next = TAG_ALTERNATE;
                                sub_left_next = sub_dec;
                                if (sub_dec == '0)
                                begin
                                    entry_phase_next = EP_ALT_LEN;
                                end
                            end
                            default:
                            begin
                                sub_left_next = {{(SubW-ByteW){1'b0}}, b};
                                entry_phase_next = (b != '0) ? EP_ALT : EP_ALT_LEN;
                            end
                        endcase
                    end
                    pay_left_next = pay_dec;
                    if (pay_dec == '0)
                    begin
                        res_last_next = 1'b1;
                        res_err_next = is_entry_kind(cur_type_reg)
                            && (entry_phase_next != EP_ALT_LEN);
                        entry_phase_next = EP_HW_LEN;
                        sub_left_next = '0;
                        marker_phase_next = MK_NONE;
                        frame_phase_next = FR_HEADER;
                    end
                end
                default:
                begin
                    res_tag_next = TAG_HEADER;
                    cur_type_next = b[KindW-1:0];
                    entry_phase_next = EP_HW_LEN;
                    sub_left_next = '0;
                    marker_phase_next = MK_NONE;
                    if (cur_type_next == KIND_END)
                    begin
                        ended_next = 1'b1;
                        res_last_next = 1'b1;
                        frame_phase_next = FR_HEADER;
                    end
                    else if (b[7:4] < CODE_INLINE_BASE)
                    begin
                        len_left_next = LenCntW'(b[5:4]) + 1'b1;
                        len_acc_next = '0;
                        frame_phase_next = FR_LENGTH;
                    end
                    else if (b[7:4] > CODE_INLINE_BASE)
                    begin
                        pay_left_next = LenW'(b[7:4] - CODE_INLINE_BASE);
                        frame_phase_next = FR_PAYLOAD;
                    end
                    else
                    begin
                        res_last_next = 1'b1;
                        res_err_next = is_entry_kind(cur_type_next);
                        frame_phase_next = FR_HEADER;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_phase_reg <= FR_HEADER;
            len_left_reg <= '0;
            len_acc_reg <= '0;
            cur_type_reg <= '0;
            pay_left_reg <= '0;
            entry_phase_reg <= EP_HW_LEN;
            sub_left_reg <= '0;
            marker_phase_reg <= MK_NONE;
            ended_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                frame_phase_reg <= frame_phase_next;
                len_left_reg <= len_left_next;
                len_acc_reg <= len_acc_next;
                cur_type_reg <= cur_type_next;
                pay_left_reg <= pay_left_next;
                entry_phase_reg <= entry_phase_next;
                sub_left_reg <= sub_left_next;
                marker_phase_reg <= marker_phase_next;
                ended_reg <= ended_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_chan.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_byte_reg <= b;
            res_kind_reg <= cur_type_next;
            res_tag_reg <= res_tag_next;
            res_class_reg <= res_class_next;
            res_index_reg <= res_index_next;
            res_svalid_reg <= res_svalid_next;
            res_last_reg <= res_last_next;
            res_ended_reg <= ended_next;
            res_err_reg <= res_err_next;
        end
    end

    assign out_chan.valid = out_valid_reg;
    assign out_chan.out_byte = res_byte_reg;
    assign out_chan.block_kind = res_kind_reg;
    assign out_chan.field_tag = res_tag_reg;
    assign out_chan.def_class = res_class_reg;
    assign out_chan.speech_index = res_index_reg;
    assign out_chan.speech_valid = res_svalid_reg;
    assign out_chan.block_last = res_last_reg;
    assign out_chan.end_seen = res_ended_reg;
    assign out_chan.format_error = res_err_reg;

endmodule
